// File: rtl/aovp_pkg.sv
// Package with character codes, register-name tables and helpers for the operand parser.
package aovp_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned POS_W   = 3;
   localparam int unsigned NAMES   = 6;

   localparam logic [POS_W-1:0] POS_MAX = 3'd7;

   // Character codes used by the form detection.
   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;   // '0'
   localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;   // '9'
   localparam logic [CHAR_W-1:0] CHAR_X      = 8'd120;  // 'x'
   localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'd36;   // '$'
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'd45;   // '-'
   localparam logic [CHAR_W-1:0] CHAR_UP_A   = 8'd65;   // 'A'
   localparam logic [CHAR_W-1:0] CHAR_UP_Z   = 8'd90;   // 'Z'
   localparam logic [CHAR_W-1:0] CHAR_LO_A   = 8'd97;   // 'a'
   localparam logic [CHAR_W-1:0] CHAR_LO_F   = 8'd102;  // 'f'
   localparam logic [CHAR_W-1:0] CHAR_LO_Z   = 8'd122;  // 'z'
   localparam logic [CHAR_W-1:0] CHAR_V      = 8'd118;  // 'v'
   localparam logic [CHAR_W-1:0] CHAR_T      = 8'd116;  // 't'
   localparam logic [CHAR_W-1:0] CHAR_S      = 8'd115;  // 's'
   localparam logic [CHAR_W-1:0] CHAR_K      = 8'd107;  // 'k'

   // Offset that turns 'a'..'f' into 10..15.
   localparam logic [VALUE_W-1:0] HEX_LETTER_BIAS = 32'd87;

   // Fixed register names, first character in the top byte.
   localparam logic [31:0] NAME_WORD [NAMES] = '{
      "zero", {"at", 16'h0}, {"gp", 16'h0}, {"sp", 16'h0}, {"fp", 16'h0}, {"ra", 16'h0}
   };
   localparam logic [POS_W-1:0] NAME_LEN [NAMES] = '{3'd4, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2};
   localparam logic [VALUE_W-1:0] NAME_VALUE [NAMES] = '{
      32'd0, 32'd1, 32'd28, 32'd29, 32'd30, 32'd31
   };

   // Base values of the numbered register groups.
   localparam logic [VALUE_W-1:0] BASE_V    = 32'd2;
   localparam logic [VALUE_W-1:0] BASE_A    = 32'd4;
   localparam logic [VALUE_W-1:0] BASE_T_LO = 32'd8;
   localparam logic [VALUE_W-1:0] BASE_T_HI = 32'd16;
   localparam logic [VALUE_W-1:0] BASE_S    = 32'd16;
   localparam logic [VALUE_W-1:0] BASE_K    = 32'd26;
   localparam logic [VALUE_W-1:0] T_SPLIT   = 32'd8;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z));
   endfunction

   // True when character c at name position k still matches the given name.
   function automatic logic prefix_keep(input logic [31:0] name, input logic [POS_W-1:0] len,
                                        input logic [POS_W-1:0] k, input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] ch;
      unique case (k[1:0])
         2'd0: ch = name[31:24];
         2'd1: ch = name[23:16];
         2'd2: ch = name[15:8];
         default: ch = name[7:0];
      endcase
      return (k < len) && (ch == c);
   endfunction

   function automatic logic [VALUE_W-1:0] times_ten(input logic [VALUE_W-1:0] x);
      return (x << 3) + (x << 1);
   endfunction

endpackage

// File: rtl/assembly_operand_value_parser_top.sv
// Top level of the assembler operand value parser.

// The parser takes one character of an operand token per request and returns the token's
// signed 32-bit value as one response, sent for the request whose last_char is set; other
// requests give no response. Hexadecimal ("0x" and at least one more character, lowercase
// letter digits), numbered registers ("$" and digits), symbolic registers ("$" and a
// letter), negated decimals ("-") and plain decimals are recognized; all sums wrap modulo
// 2^32. A request is registered in an input stage and processed when it moves on from there:
// one multiply-by-ten add per accumulator, the register-name match and the form selection
// sit between the input stage and the response register. The block accepts one character
// every cycle while no response waits for rsp_ready; a last character passes the input
// stage and then the response register. While a response waits for rsp_ready, one more
// character can be held in the input stage; throughput then follows the response side.
module assembly_operand_value_parser_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_operand_value
);

   // Input stage.
   logic                                   in_valid_ff;
   logic [aovp_pkg::CHAR_W-1:0]            in_char_ff;
   logic                                   in_last_ff;
   logic                                   advance;

   // Token state.
   logic [aovp_pkg::POS_W-1:0]   char_position_ff, char_position_in;
   logic [aovp_pkg::CHAR_W-1:0]  lead_char_ff, lead_char_in;
   logic [aovp_pkg::CHAR_W-1:0]  reg_first_char_ff, reg_first_char_in;
   logic                         reg_second_is_digit_ff, reg_second_is_digit_in;
   logic [aovp_pkg::VALUE_W-1:0] hex_accumulator_ff, hex_accumulator_in;
   logic [aovp_pkg::VALUE_W-1:0] dec_from_first_ff, dec_from_first_in;
   logic [aovp_pkg::VALUE_W-1:0] dec_from_second_ff, dec_from_second_in;
   logic [aovp_pkg::VALUE_W-1:0] dec_from_third_ff, dec_from_third_in;
   logic [aovp_pkg::NAMES-1:0]   name_prefix_flags_ff, name_prefix_flags_in;

   // Response register.
   logic                         rsp_valid_ff;
   logic [aovp_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [aovp_pkg::VALUE_W-1:0] digit;
   logic [aovp_pkg::VALUE_W-1:0] hex_digit;
   logic [aovp_pkg::POS_W-1:0]   name_index;
   logic [aovp_pkg::VALUE_W-1:0] symbolic_value;

   // The input stage moves on when the response register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_operand_value = rsp_value_ff;

   always_comb begin
      digit     = {24'd0, in_char_ff} - {24'd0, aovp_pkg::CHAR_ZERO};
      hex_digit = digit;
      if ((in_char_ff >= aovp_pkg::CHAR_LO_A) && (in_char_ff <= aovp_pkg::CHAR_LO_F)) begin
         hex_digit = {24'd0, in_char_ff} - aovp_pkg::HEX_LETTER_BIAS;
      end
      name_index = char_position_ff - 3'd1;

      // Every character feeds the decimal value that starts at the first character; the
      // later accumulators start counting at their own character position.
      dec_from_first_in      = aovp_pkg::times_ten(dec_from_first_ff) + digit;
      dec_from_second_in     = dec_from_second_ff;
      dec_from_third_in      = dec_from_third_ff;
      hex_accumulator_in     = hex_accumulator_ff;
      name_prefix_flags_in   = name_prefix_flags_ff;
      lead_char_in           = lead_char_ff;
      reg_first_char_in      = reg_first_char_ff;
      reg_second_is_digit_in = reg_second_is_digit_ff;

      if (char_position_ff >= 3'd1) begin
         dec_from_second_in = aovp_pkg::times_ten(dec_from_second_ff) + digit;
         for (int j = 0; j < aovp_pkg::NAMES; j++) begin
            if (!aovp_pkg::prefix_keep(aovp_pkg::NAME_WORD[j], aovp_pkg::NAME_LEN[j],
                                       name_index, in_char_ff)) begin
               name_prefix_flags_in[j] = 1'b0;
            end
         end
      end
      if (char_position_ff >= 3'd2) begin
         dec_from_third_in  = aovp_pkg::times_ten(dec_from_third_ff) + digit;
         hex_accumulator_in = (hex_accumulator_ff << 4) + hex_digit;
      end
      if (char_position_ff == 3'd0) begin
         lead_char_in = in_char_ff;
      end
      if (char_position_ff == 3'd1) begin
         reg_first_char_in = in_char_ff;
      end
      if (char_position_ff == 3'd2) begin
         reg_second_is_digit_in = aovp_pkg::is_digit(in_char_ff);
      end
      char_position_in = (char_position_ff == aovp_pkg::POS_MAX) ?
                         aovp_pkg::POS_MAX : char_position_ff + 3'd1;

      // Symbolic register names; the order of the checks decides.
      symbolic_value = '0;
      priority if (name_prefix_flags_in[0]) begin
         symbolic_value = aovp_pkg::NAME_VALUE[0];
      end else if (name_prefix_flags_in[1]) begin
         symbolic_value = aovp_pkg::NAME_VALUE[1];
      end else if (reg_second_is_digit_in && (reg_first_char_in == aovp_pkg::CHAR_V)) begin
         symbolic_value = aovp_pkg::BASE_V + dec_from_third_in;
      end else if (reg_second_is_digit_in && (reg_first_char_in == aovp_pkg::CHAR_LO_A)) begin
         symbolic_value = aovp_pkg::BASE_A + dec_from_third_in;
      end else if (reg_second_is_digit_in && (reg_first_char_in == aovp_pkg::CHAR_T)) begin
         if ($signed(dec_from_third_in) < $signed(aovp_pkg::T_SPLIT)) begin
            symbolic_value = aovp_pkg::BASE_T_LO + dec_from_third_in;
         end else begin
            symbolic_value = aovp_pkg::BASE_T_HI + dec_from_third_in;
         end
      end else if (reg_second_is_digit_in && (reg_first_char_in == aovp_pkg::CHAR_S)) begin
         symbolic_value = aovp_pkg::BASE_S + dec_from_third_in;
      end else if (reg_second_is_digit_in && (reg_first_char_in == aovp_pkg::CHAR_K)) begin
         symbolic_value = aovp_pkg::BASE_K + dec_from_third_in;
      end else if (name_prefix_flags_in[2]) begin
         symbolic_value = aovp_pkg::NAME_VALUE[2];
      end else if (name_prefix_flags_in[3]) begin
         symbolic_value = aovp_pkg::NAME_VALUE[3];
      end else if (name_prefix_flags_in[4]) begin
         symbolic_value = aovp_pkg::NAME_VALUE[4];
      end else if (name_prefix_flags_in[5]) begin
         symbolic_value = aovp_pkg::NAME_VALUE[5];
      end else begin
         // A letter that starts no known name gives zero.
         symbolic_value = '0;
      end

      // Form selection on the token as it stands after this character.
      priority if ((char_position_in > 3'd2) && (lead_char_in == aovp_pkg::CHAR_ZERO) &&
                   (reg_first_char_in == aovp_pkg::CHAR_X)) begin
         rsp_value_in = hex_accumulator_in;
      end else if (lead_char_in == aovp_pkg::CHAR_DOLLAR) begin
         if ((char_position_in >= 3'd2) && aovp_pkg::is_letter(reg_first_char_in)) begin
            rsp_value_in = symbolic_value;
         end else begin
            rsp_value_in = dec_from_second_in;
         end
      end else if (lead_char_in == aovp_pkg::CHAR_MINUS) begin
         rsp_value_in = '0 - dec_from_second_in;
      end else begin
         rsp_value_in = dec_from_first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         char_position_ff       <= '0;
         lead_char_ff           <= '0;
         reg_first_char_ff      <= '0;
         reg_second_is_digit_ff <= 1'b0;
         hex_accumulator_ff     <= '0;
         dec_from_first_ff      <= '0;
         dec_from_second_ff     <= '0;
         dec_from_third_ff      <= '0;
         name_prefix_flags_ff   <= '1;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
            in_char_ff  <= req_char_code;
            in_last_ff  <= req_last_char;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= in_last_ff;
            if (in_last_ff) begin
               rsp_value_ff <= rsp_value_in;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (advance) begin
            // The last character of a token returns the state to its start values.
            if (in_last_ff) begin
               char_position_ff       <= '0;
               lead_char_ff           <= '0;
               reg_first_char_ff      <= '0;
               reg_second_is_digit_ff <= 1'b0;
               hex_accumulator_ff     <= '0;
               dec_from_first_ff      <= '0;
               dec_from_second_ff     <= '0;
               dec_from_third_ff      <= '0;
               name_prefix_flags_ff   <= '1;
            end else begin
               char_position_ff       <= char_position_in;
               lead_char_ff           <= lead_char_in;
               reg_first_char_ff      <= reg_first_char_in;
               reg_second_is_digit_ff <= reg_second_is_digit_in;
               hex_accumulator_ff     <= hex_accumulator_in;
               dec_from_first_ff      <= dec_from_first_in;
               dec_from_second_ff     <= dec_from_second_in;
               dec_from_third_ff      <= dec_from_third_in;
               name_prefix_flags_ff   <= name_prefix_flags_in;
            end
         end
      end
   end

endmodule

// File: rtl/aovp_checker.sv
// Port-level checker for the operand parser and its bind to the top level.
module aovp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_char,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_operand_value
);

   // A response held back by the consumer keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_operand_value))
      else $error("response changed while stalled");

   // Reset empties the response register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With the consumer ready, the parser never stalls a request.
   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // A new response comes from an earlier accepted last character.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_char, 2))
      else $error("response without a last character");

endmodule

bind assembly_operand_value_parser_top aovp_checker u_aovp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_last_char     (req_last_char),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_operand_value (rsp_operand_value)
);
